>>> sv/bdrd_pkg.sv
// ----------------------------------------------------------------------------
// bdrd_pkg
// Shared widths, constants and controller/datapath interface types for the
// business-day return date block.
// ----------------------------------------------------------------------------
`default_nettype none

package bdrd_pkg;

  // field widths
  localparam int DayW   = 5;
  localparam int MonthW = 4;
  localparam int YearW  = 12;
  localparam int WdayW  = 3;
  localparam int CntW   = 6;
  localparam int MaskW  = 7;

  // weekend mask: reset marks friday and saturday
  localparam logic [MaskW-1:0] WeekendMaskReset = 7'd96;
  localparam logic [MaskW-1:0] MaskAllDays      = 7'd127;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic div_y;
    logic div_yy;
    logic sum;
    logic mod;
    logic step;
    logic finish;
  } bdrd_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic bad;
    logic cnt_zero;
  } bdrd_status_t;

endpackage

`default_nettype wire

>>> sv/bdrd_ctrl.sv
// ----------------------------------------------------------------------------
// bdrd_ctrl
// Sequencer: setup steps for weekday and leap-year state, then one calendar
// day per cycle until the business-day count is used up or status flags bad.
// ----------------------------------------------------------------------------
`default_nettype none

module bdrd_ctrl (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    start_i,
  input  bdrd_pkg::bdrd_status_t status_i,
  output bdrd_pkg::bdrd_cmd_t    cmd_o,
  output logic                   busy_o
);
  import bdrd_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DIV_Y  = 3'd1;
  localparam logic [2:0] S_DIV_YY = 3'd2;
  localparam logic [2:0] S_SUM    = 3'd3;
  localparam logic [2:0] S_MOD    = 3'd4;
  localparam logic [2:0] S_WALK   = 3'd5;

  logic [2:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DIV_Y;
        end
      end
      S_DIV_Y: begin
        cmd_o.div_y = 1'b1;
        state_d     = S_DIV_YY;
      end
      S_DIV_YY: begin
        cmd_o.div_yy = 1'b1;
        state_d      = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_MOD;
      end
      S_MOD: begin
        cmd_o.mod = 1'b1;
        state_d   = S_WALK;
      end
      S_WALK: begin
        if (status_i.bad || status_i.cnt_zero) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

>>> sv/bdrd_dpath.sv
// ----------------------------------------------------------------------------
// bdrd_dpath
// Date registers, weekend mask, weekday setup arithmetic and the one-day
// advance step, plus the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bdrd_dpath (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  bdrd_pkg::bdrd_cmd_t               cmd_i,
  output bdrd_pkg::bdrd_status_t            status_o,
  input  wire                               cfg_we_i,
  input  wire  [bdrd_pkg::MaskW-1:0]        cfg_data_i,
  input  wire  [bdrd_pkg::DayW-1:0]         start_day_i,
  input  wire  [bdrd_pkg::MonthW-1:0]       start_month_i,
  input  wire  [bdrd_pkg::YearW-1:0]        start_year_i,
  input  wire  [bdrd_pkg::CntW-1:0]         vacation_days_i,
  output logic                              done_o,
  output logic [bdrd_pkg::DayW-1:0]         return_day_o,
  output logic [bdrd_pkg::MonthW-1:0]       return_month_o,
  output logic [bdrd_pkg::YearW-1:0]        return_year_o,
  output logic [bdrd_pkg::WdayW-1:0]        return_weekday_o,
  output logic                              date_error_o
);
  import bdrd_pkg::*;

  // divide by 100 as multiply by reciprocal, exact for 12-bit years
  localparam logic [12:0] Recip100   = 13'd5243;
  localparam int          RecipShift = 19;
  localparam int          ProdW      = YearW + 13;
  localparam int          QuotW      = 6;

  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;
  localparam logic [YearW-1:0]  MaxYear  = 12'd3000;
  localparam logic [WdayW-1:0]  WdaySat  = 3'd6;

  // month length for the current year's leap flag
  function automatic logic [DayW-1:0] days_in(input logic [MonthW-1:0] m,
                                              input logic leap);
    logic [DayW-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
      4'd2:                                      len = leap ? 5'd29 : 5'd28;
      default:                                   len = 5'd0;
    endcase
    return len;
  endfunction

  // (31 * shifted month) / 12 term of the weekday formula
  function automatic logic [4:0] month_off(input logic [MonthW-1:0] m);
    logic [4:0] off;
    case (m)
      4'd1:    off = 5'd28;
      4'd2:    off = 5'd31;
      4'd3:    off = 5'd2;
      4'd4:    off = 5'd5;
      4'd5:    off = 5'd7;
      4'd6:    off = 5'd10;
      4'd7:    off = 5'd12;
      4'd8:    off = 5'd15;
      4'd9:    off = 5'd18;
      4'd10:   off = 5'd20;
      4'd11:   off = 5'd23;
      4'd12:   off = 5'd25;
      default: off = 5'd0;
    endcase
    return off;
  endfunction

  // modulo 7 by folding octal digits (8 = 1 mod 7)
  function automatic logic [WdayW-1:0] mod7(input logic [13:0] s);
    logic [4:0] a;
    logic [3:0] b;
    a = 5'(s[2:0]) + 5'(s[5:3]) + 5'(s[8:6]) + 5'(s[11:9]) + 5'(s[13:12]);
    b = 4'(a[2:0]) + 4'(a[4:3]);
    return (b >= 4'd7) ? 3'(b - 4'd7) : 3'(b);
  endfunction

  logic [MaskW-1:0]  mask_q;
  logic [DayW-1:0]   day_q;
  logic [MonthW-1:0] month_q;
  logic [YearW-1:0]  year_q;
  logic [CntW-1:0]   cnt_q;
  logic [WdayW-1:0]  wday_q;
  logic [QuotW-1:0]  q_y_q;
  logic [QuotW-1:0]  q_yy_q;
  logic [6:0]        r100_q;
  logic [1:0]        c400_q;
  logic [13:0]       sum_q;
  logic              bad_q;
  logic              done_q;

  logic [YearW-1:0]  yy;
  logic [ProdW-1:0]  prod_y;
  logic [ProdW-1:0]  prod_yy;
  logic [YearW-1:0]  hundreds;
  logic              leap;
  logic [DayW-1:0]   mlen;
  logic              last_day;
  logic [13:0]       sum_d;
  logic              bad_d;

  // year shifted so that the year starts in march
  assign yy = year_q - ((month_q <= MonthFeb) ? 12'd1 : 12'd0);

  assign prod_y   = ProdW'(year_q) * ProdW'(Recip100);
  assign prod_yy  = ProdW'(yy) * ProdW'(Recip100);
  assign hundreds = YearW'(q_y_q) * 12'd100;

  // leap flag from year mod 4, year mod 100 and century mod 4
  assign leap     = ((year_q[1:0] == 2'd0) && (r100_q != 7'd0)) ||
                    ((r100_q == 7'd0) && (c400_q == 2'd0));
  assign mlen     = days_in(month_q, leap);
  assign last_day = (day_q == mlen);

  assign sum_d = 14'(day_q) + 14'(yy) + 14'(yy >> 2) - 14'(q_yy_q)
               + 14'(q_yy_q >> 2) + 14'(month_off(month_q));

  assign bad_d = (year_q == '0) || (year_q > MaxYear) ||
                 (month_q == '0) || (month_q > MonthDec) ||
                 (day_q == '0) || (day_q > mlen) ||
                 ((cnt_q != '0) && (mask_q == MaskAllDays));

  // weekend mask register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= WeekendMaskReset;
    end else if (cfg_we_i) begin
      mask_q <= cfg_data_i;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      day_q   <= start_day_i;
      month_q <= start_month_i;
      year_q  <= start_year_i;
      cnt_q   <= vacation_days_i;
    end
    if (cmd_i.div_y) begin
      q_y_q <= prod_y[RecipShift +: QuotW];
    end
    if (cmd_i.div_yy) begin
      q_yy_q <= prod_yy[RecipShift +: QuotW];
      r100_q <= 7'(year_q - hundreds);
      c400_q <= q_y_q[1:0];
    end
    if (cmd_i.sum) begin
      sum_q <= sum_d;
      bad_q <= bad_d;
    end
    if (cmd_i.mod) begin
      wday_q <= mod7(sum_q);
    end
    // one calendar day forward
    if (cmd_i.step) begin
      if (!mask_q[wday_q]) begin
        cnt_q <= cnt_q - 6'd1;
      end
      if (last_day) begin
        day_q <= 5'd1;
        if (month_q == MonthDec) begin
          month_q <= MonthJan;
          year_q  <= year_q + 12'd1;
          if (r100_q == 7'd99) begin
            r100_q <= 7'd0;
            c400_q <= c400_q + 2'd1;
          end else begin
            r100_q <= r100_q + 7'd1;
          end
        end else begin
          month_q <= month_q + 4'd1;
        end
      end else begin
        day_q <= day_q + 5'd1;
      end
      wday_q <= (wday_q == WdaySat) ? 3'd0 : wday_q + 3'd1;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      if (bad_q) begin
        return_day_o     <= '0;
        return_month_o   <= '0;
        return_year_o    <= '0;
        return_weekday_o <= '0;
        date_error_o     <= 1'b1;
      end else begin
        return_day_o     <= day_q;
        return_month_o   <= month_q;
        return_year_o    <= year_q;
        return_weekday_o <= wday_q;
        date_error_o     <= 1'b0;
      end
    end
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
    end
  end

  assign done_o            = done_q;
  assign status_o.bad      = bad_q;
  assign status_o.cnt_zero = (cnt_q == '0);

endmodule

`default_nettype wire

>>> sv/business_day_return_date.sv
// ----------------------------------------------------------------------------
// business_day_return_date
// Return date after a number of business days from a Gregorian start date,
// with a programmable weekend mask.
// ----------------------------------------------------------------------------
// An item is taken when start_i is high and busy_o is low. It then occupies
// the block while four setup steps find the weekday and the leap-year state
// (divide by 100 by reciprocal multiply, modulo 7 by digit folding), then
// the walk advances one calendar day per cycle, and a last step hands over
// the result. 32 business days with a two-day weekend take about 46 days;
// a sparse mask stretches the walk, and 63 business days with only one
// business day per week walk up to 441 days. An invalid start date walks no
// days. done_o is high for exactly one cycle, the first cycle with busy_o
// low again, with the result on the return ports; it cannot be held off,
// so capture it in that cycle. A new start may be given in that same
// cycle. The weekend mask is written through the cfg port while the block
// is not busy; it resets to friday and saturday.
// ----------------------------------------------------------------------------
`default_nettype none

module business_day_return_date (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // command
  input  wire                          start_i,
  output logic                         busy_o,
  input  wire  [bdrd_pkg::DayW-1:0]    start_day_i,
  input  wire  [bdrd_pkg::MonthW-1:0]  start_month_i,
  input  wire  [bdrd_pkg::YearW-1:0]   start_year_i,
  input  wire  [bdrd_pkg::CntW-1:0]    vacation_days_i,
  // result
  output logic                         done_o,
  output logic [bdrd_pkg::DayW-1:0]    return_day_o,
  output logic [bdrd_pkg::MonthW-1:0]  return_month_o,
  output logic [bdrd_pkg::YearW-1:0]   return_year_o,
  output logic [bdrd_pkg::WdayW-1:0]   return_weekday_o,
  output logic                         date_error_o,
  // weekend mask write
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire  [bdrd_pkg::MaskW-1:0]   cfg_data_i
);
  import bdrd_pkg::*;

  bdrd_cmd_t    cmd;
  bdrd_status_t status;
  logic         cfg_we;

  // mask transfer only while idle
  assign cfg_ready_o = !busy_o;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  bdrd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  bdrd_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_we_i         (cfg_we),
    .cfg_data_i       (cfg_data_i),
    .start_day_i      (start_day_i),
    .start_month_i    (start_month_i),
    .start_year_i     (start_year_i),
    .vacation_days_i  (vacation_days_i),
    .done_o           (done_o),
    .return_day_o     (return_day_o),
    .return_month_o   (return_month_o),
    .return_year_o    (return_year_o),
    .return_weekday_o (return_weekday_o),
    .date_error_o     (date_error_o)
  );

  // result strobe comes only once the sequencer is back to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy_o)
    else $error("result strobe while busy");

  // an accepted start always makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("start accepted but block not busy");

  // strobe lasts one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // error results carry an all-zero date
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && date_error_o) |->
      (return_day_o == '0 && return_month_o == '0 &&
       return_year_o == '0 && return_weekday_o == '0))
    else $error("error result with nonzero date");

  // good results carry a plausible date
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !date_error_o) |->
      (return_day_o != '0 && return_month_o != '0 &&
       return_month_o <= 4'd12 && return_weekday_o <= 3'd6))
    else $error("result date out of range");

endmodule

`default_nettype wire
